>>> src/pshrm_pkg.sv
// Shared types and constants for the per-source history ring merge block.
// Depends on nothing; every module of the block imports it.
package pshrm_pkg;

    // Default sizes of the ring store.
    localparam int THREADS_DEF = 8;
    localparam int DEPTH_DEF   = 8;

    // Most records one read may return, and the reset value of the source count.
    localparam logic [6:0] MAX_OUT           = 7'd64;
    localparam logic [3:0] ACTIVE_RESET      = 4'd8;
    localparam logic [31:0] FIRST_RECORD_ID  = 32'd1;

    // Operation codes on the func field.
    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Record contents held in the payload memory (the id lives apart).
    typedef struct packed {
        logic [31:0] height;
        logic [63:0] rate;
        logic [63:0] difficulty;
        logic [63:0] hashes;
        logic        found;
        logic [31:0] stamp;
    } rec_payload_t;

endpackage

>>> src/per_source_history_ring_merge.sv
// Top level of the per-source history ring merge block: ring store, merge sequencer
// and output register. Depends on pshrm_pkg.
//
// Usage. Commands arrive as beats on the in_valid / in_ready channel: an add stores a
// record in the ring of its source under the next global id, a clear empties every
// ring and sets the id back to one, and a read returns up to max_records records,
// newest first, merged over all active sources or restricted to one. Result beats
// leave on the out_valid / out_ready channel; every read ends with a beat marked last,
// and a read that finds nothing sends a single beat with record_valid low.
// Flow. An add or a clear is taken while the block is idle, and the block is ready
// again in the next cycle. A read takes, per record, one pass of the shared id
// comparator over the active sources (one id memory read each), a fetch of the
// record from the payload memory in the FETCH and LOAD states and a hand-over of
// the beat in EMIT, which may wait on the receiver.
// The block takes no new command until the last beat of a read has been accepted.
// A stalled receiver simply holds the result beat; nothing is lost or repeated.
// Reset empties all rings, sets the id to one and the active count to eight. The
// record memories are not cleared: an entry is only ever read after it was written.
module per_source_history_ring_merge #(
    parameter int THREADS = pshrm_pkg::THREADS_DEF,
    parameter int DEPTH   = pshrm_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data,
    // Command channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic signed [3:0] thread,
    input  logic [31:0] height,
    input  logic [63:0] hashrate_bits,
    input  logic [63:0] difficulty_bits,
    input  logic [63:0] hash_total,
    input  logic        found,
    input  logic [31:0] timestamp,
    input  logic [6:0]  max_records,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] record_id,
    output logic [2:0]  source,
    output logic [31:0] out_height,
    output logic [63:0] out_rate_bits,
    output logic [63:0] out_difficulty_bits,
    output logic [63:0] out_hash_total,
    output logic        out_found,
    output logic [31:0] out_time,
    output logic        record_valid,
    output logic        last
);

    import pshrm_pkg::*;

    localparam int THR_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int IDX_W  = $clog2(THREADS + 1);
    localparam int DEP_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ENTRIES = THREADS * DEPTH;
    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int HS_W   = DEP_W + 1;

    // Sequencer state
    state_t state_reg, state_next;

    // Configuration and ring bookkeeping
    logic [3:0]        active_cfg_reg;
    logic [DEP_W-1:0]  wp_reg    [THREADS];
    logic [CNT_W-1:0]  fill_reg  [THREADS];
    logic [CNT_W-1:0]  taken_reg [THREADS];
    logic [31:0]       next_id_reg;

    // Read command context
    logic              all_reg;
    logic [2:0]        filt_reg;
    logic [6:0]        maxr_reg;
    logic [6:0]        count_reg;
    logic              next_pend_reg;

    // Scan pipeline and running best
    logic [IDX_W-1:0]  idx_reg;
    logic              p_valid_reg;
    logic [THR_W-1:0]  p_t_reg;
    logic [ADDR_W-1:0] p_slot_reg;
    logic              have_reg;
    logic [THR_W-1:0]  best_t_reg;
    logic [31:0]       best_id_reg;
    logic [ADDR_W-1:0] best_slot_reg;

    // Memories and their read registers
    logic [31:0]       id_mem  [ENTRIES];
    rec_payload_t      pay_mem [ENTRIES];
    logic [31:0]       id_rd_reg;
    rec_payload_t      pay_rd_reg;

    // Output register
    logic [31:0]       o_id_reg;
    logic [2:0]        o_src_reg;
    rec_payload_t      o_pay_reg;
    logic              o_valid_rec_reg;
    logic              o_last_reg;

    // Combinational helpers
    logic [IDX_W-1:0]  active;
    logic              accept;
    logic              add_ok;
    logic [7:0]        thr8;
    logic [THR_W-1:0]  add_t;
    logic [HS_W-1:0]   add_hsum;
    logic [ADDR_W-1:0] wr_addr;
    logic [6:0]        maxr_eff;
    logic [THR_W-1:0]  idx_t;
    logic              issue_en;
    logic              elig;
    logic [HS_W-1:0]   hsum;
    logic [DEP_W-1:0]  head;
    logic [ADDR_W-1:0] rd_addr;
    logic              cand;
    logic              have_c;
    logic [THR_W-1:0]  best_t_c;
    logic [31:0]       best_id_c;
    logic [ADDR_W-1:0] best_slot_c;
    logic              scan_done;
    logic              read_full;
    logic [7:0]        best_t8;

    // Number of sources in use, limited to the ring count.
    always_comb
    begin
        if ({28'd0, active_cfg_reg} >= 32'(THREADS))
            active = IDX_W'(THREADS);
        else
            active = IDX_W'(active_cfg_reg);
    end

    // Add path: ring slot of the source named by the command.
    assign accept   = in_valid && in_ready;
    assign thr8     = {5'd0, thread[2:0]};
    assign add_ok   = !thread[3] && (thr8 < 8'(active));
    assign add_t    = thr8[THR_W-1:0];
    assign add_hsum = HS_W'(wp_reg[add_t]);
    assign wr_addr  = ADDR_W'(add_t) * ADDR_W'(DEPTH) + ADDR_W'(add_hsum);
    assign maxr_eff = (max_records > MAX_OUT) ? MAX_OUT : max_records;

    // Scan issue: head slot of the source under the index counter.
    assign idx_t    = idx_reg[THR_W-1:0];
    assign issue_en = (state_reg == ST_SCAN) && (idx_reg < active);
    assign elig     = issue_en && (all_reg || ({5'd0, filt_reg} == 8'(idx_t)))
                      && (taken_reg[idx_t] < fill_reg[idx_t]);
    assign hsum     = HS_W'(wp_reg[idx_t]) + HS_W'(DEPTH - 1) - HS_W'(taken_reg[idx_t]);

    always_comb
    begin
        if (hsum >= HS_W'(DEPTH))
            head = DEP_W'(hsum - HS_W'(DEPTH));
        else
            head = DEP_W'(hsum);
    end

    assign rd_addr = ADDR_W'(idx_t) * ADDR_W'(DEPTH) + ADDR_W'(head);

    // Shared comparator: the newer id wins, a tie keeps the lower source.
    assign cand        = p_valid_reg && (!have_reg || (id_rd_reg > best_id_reg));
    assign have_c      = have_reg || p_valid_reg;
    assign best_t_c    = cand ? p_t_reg    : best_t_reg;
    assign best_id_c   = cand ? id_rd_reg  : best_id_reg;
    assign best_slot_c = cand ? p_slot_reg : best_slot_reg;
    assign scan_done   = (state_reg == ST_SCAN) && (idx_reg == active);
    assign read_full   = (count_reg == maxr_reg);
    assign best_t8     = 8'(best_t_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func_t'(func) == FUNC_READ))
                    state_next = (maxr_eff == 7'd0) ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if ((count_reg == 7'd0) && have_c)
                        state_next = ST_FETCH;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_FETCH:
                state_next = ST_LOAD;
            ST_LOAD:
                state_next = read_full ? ST_EMIT : ST_SCAN;
            ST_EMIT:
            begin
                if (out_ready)
                    state_next = next_pend_reg ? ST_FETCH : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_cfg_reg <= ACTIVE_RESET;
        else if (cfg_write_en)
            active_cfg_reg <= cfg_write_data;
    end

    // Ring pointers, fill counts and the record id.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
            next_id_reg <= FIRST_RECORD_ID;
        end
        else if (accept && (func_t'(func) == FUNC_CLEAR))
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
            next_id_reg <= FIRST_RECORD_ID;
        end
        else if (accept && (func_t'(func) == FUNC_ADD) && add_ok)
        begin
            if (wp_reg[add_t] == DEP_W'(DEPTH - 1))
                wp_reg[add_t] <= '0;
            else
                wp_reg[add_t] <= wp_reg[add_t] + DEP_W'(1);
            if (fill_reg[add_t] < CNT_W'(DEPTH))
                fill_reg[add_t] <= fill_reg[add_t] + CNT_W'(1);
            next_id_reg <= next_id_reg + 32'd1;
        end
    end

    // Record memories: one write port for adds, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (accept && (func_t'(func) == FUNC_ADD) && add_ok)
            id_mem[wr_addr] <= next_id_reg;
        id_rd_reg <= id_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && (func_t'(func) == FUNC_ADD) && add_ok)
            pay_mem[wr_addr] <= '{height, hashrate_bits, difficulty_bits, hash_total,
                                  found, timestamp};
        pay_rd_reg <= pay_mem[best_slot_reg];
    end

    // Read sequencer datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_reg         <= 1'b0;
            filt_reg        <= '0;
            maxr_reg        <= '0;
            count_reg       <= '0;
            next_pend_reg   <= 1'b0;
            idx_reg         <= '0;
            p_valid_reg     <= 1'b0;
            p_t_reg         <= '0;
            p_slot_reg      <= '0;
            have_reg        <= 1'b0;
            best_t_reg      <= '0;
            best_id_reg     <= '0;
            best_slot_reg   <= '0;
            o_id_reg        <= '0;
            o_src_reg       <= '0;
            o_pay_reg       <= '0;
            o_valid_rec_reg <= 1'b0;
            o_last_reg      <= 1'b0;
            for (int i = 0; i < THREADS; i++)
                taken_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Start of a read: clear the merge cursors.
                    if (accept && (func_t'(func) == FUNC_READ))
                    begin
                        all_reg       <= thread[3];
                        filt_reg      <= thread[2:0];
                        maxr_reg      <= maxr_eff;
                        count_reg     <= '0;
                        next_pend_reg <= 1'b0;
                        idx_reg       <= '0;
                        p_valid_reg   <= 1'b0;
                        have_reg      <= 1'b0;
                        for (int i = 0; i < THREADS; i++)
                            taken_reg[i] <= '0;
                        if (maxr_eff == 7'd0)
                        begin
                            o_id_reg        <= '0;
                            o_src_reg       <= '0;
                            o_pay_reg       <= '0;
                            o_valid_rec_reg <= 1'b0;
                            o_last_reg      <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // One source head per cycle through the comparator.
                    if (issue_en)
                        idx_reg <= idx_reg + IDX_W'(1);
                    p_valid_reg   <= elig;
                    p_t_reg       <= idx_t;
                    p_slot_reg    <= rd_addr;
                    have_reg      <= have_c;
                    best_t_reg    <= best_t_c;
                    best_id_reg   <= best_id_c;
                    best_slot_reg <= best_slot_c;
                    if (scan_done)
                    begin
                        next_pend_reg <= have_c;
                        if (have_c)
                        begin
                            taken_reg[best_t_c] <= taken_reg[best_t_c] + CNT_W'(1);
                            count_reg           <= count_reg + 7'd1;
                        end
                        if (count_reg == 7'd0)
                        begin
                            if (!have_c)
                            begin
                                o_id_reg        <= '0;
                                o_src_reg       <= '0;
                                o_pay_reg       <= '0;
                                o_valid_rec_reg <= 1'b0;
                                o_last_reg      <= 1'b1;
                            end
                        end
                        else
                            o_last_reg <= !have_c;
                    end
                end
                ST_FETCH:
                begin
                    // Payload read of the chosen slot is under way.
                end
                ST_LOAD:
                begin
                    // Stage the fetched record; its last flag waits for the next scan.
                    o_id_reg        <= best_id_reg;
                    o_src_reg       <= best_t8[2:0];
                    o_pay_reg       <= pay_rd_reg;
                    o_valid_rec_reg <= 1'b1;
                    o_last_reg      <= read_full;
                    next_pend_reg   <= 1'b0;
                    idx_reg         <= '0;
                    p_valid_reg     <= 1'b0;
                    have_reg        <= 1'b0;
                end
                ST_EMIT:
                begin
                    // Beat held until the receiver takes it.
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result beat fields.
    assign record_id           = o_id_reg;
    assign source              = o_src_reg;
    assign out_height          = o_pay_reg.height;
    assign out_rate_bits       = o_pay_reg.rate;
    assign out_difficulty_bits = o_pay_reg.difficulty;
    assign out_hash_total      = o_pay_reg.hashes;
    assign out_found           = o_pay_reg.found;
    assign out_time            = o_pay_reg.stamp;
    assign record_valid        = o_valid_rec_reg;
    assign last                = o_last_reg;

endmodule

>>> bench/ring_merge_checker.sv
`timescale 1ns / 100ps
// Checker for the per-source history ring merge block: follows commands and register
// writes, predicts the result beats of each read and compares them. Uses pshrm_pkg.
module ring_merge_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic signed [3:0] thread,
    input  logic [31:0] height,
    input  logic [63:0] hashrate_bits,
    input  logic [63:0] difficulty_bits,
    input  logic [63:0] hash_total,
    input  logic        found,
    input  logic [31:0] timestamp,
    input  logic [6:0]  max_records,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] record_id,
    input  logic [2:0]  source,
    input  logic [31:0] out_height,
    input  logic [63:0] out_rate_bits,
    input  logic [63:0] out_difficulty_bits,
    input  logic [63:0] out_hash_total,
    input  logic        out_found,
    input  logic [31:0] out_time,
    input  logic        record_valid,
    input  logic        last,
    output int          failures,
    output int          outstanding
);

    import pshrm_pkg::*;

    localparam int NUM_SRC     = THREADS_DEF;
    localparam int RING_DEPTH  = DEPTH_DEF;

    // One result beat as the block should send it.
    typedef struct packed {
        logic [31:0]  id;
        logic [2:0]   src;
        rec_payload_t rec;
        logic         valid;
        logic         last;
    } result_beat_t;

    // Own copy of the ring store and of the source count.
    logic [31:0]  ring_id  [NUM_SRC][RING_DEPTH];
    rec_payload_t ring_rec [NUM_SRC][RING_DEPTH];
    int unsigned  wr_ptr   [NUM_SRC];
    int unsigned  fill     [NUM_SRC];
    logic [31:0]  id_next;
    logic [3:0]   active_cfg;

    result_beat_t beats_due [$];
    int           errors = 0;

    assign failures = errors;

    // Empties every ring and restarts the id sequence.
    function automatic void clear_history();
        foreach (wr_ptr[i])
        begin
            wr_ptr[i] = 0;
            fill[i]   = 0;
        end
        id_next = FIRST_RECORD_ID;
    endfunction

    task automatic check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_beat_t batch [$];
        result_beat_t want;
        int unsigned  taken [NUM_SRC];
        int unsigned  n_src;
        int unsigned  limit;
        int unsigned  t;
        int unsigned  slot;
        int unsigned  best_t;
        int unsigned  best_slot;
        logic [31:0]  best_id;
        bit           have;
        bit           everyone;
        logic [2:0]   sel;
        func_t        op;

        if (!rst_n)
        begin
            clear_history();
            active_cfg = ACTIVE_RESET;
            beats_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
                active_cfg = cfg_write_data;

            // Compare a result beat with the oldest one still due.
            if (out_valid && out_ready)
            begin
                if (beats_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat expected none, got id %h last %b",
                             $time, record_id, last);
                end
                else
                begin
                    want = beats_due.pop_front();
                    check_field("record_id", 64'(want.id), 64'(record_id));
                    check_field("source", 64'(want.src), 64'(source));
                    check_field("out_height", 64'(want.rec.height), 64'(out_height));
                    check_field("out_rate_bits", want.rec.rate, out_rate_bits);
                    check_field("out_difficulty_bits", want.rec.difficulty,
                                out_difficulty_bits);
                    check_field("out_hash_total", want.rec.hashes, out_hash_total);
                    check_field("out_found", 64'(want.rec.found), 64'(out_found));
                    check_field("out_time", 64'(want.rec.stamp), 64'(out_time));
                    check_field("record_valid", 64'(want.valid), 64'(record_valid));
                    check_field("last", 64'(want.last), 64'(last));
                end
            end

            // Work out what an accepted command does to the rings.
            if (in_valid && in_ready)
            begin
                op       = func_t'(func);
                everyone = thread[3];
                sel      = thread[2:0];
                n_src    = (int'(active_cfg) > NUM_SRC) ? NUM_SRC : int'(active_cfg);
                case (op)
                    FUNC_CLEAR:
                        clear_history();
                    FUNC_ADD:
                    begin
                        // Adds for a source that is not in use are dropped.
                        if (!everyone && 32'(sel) < n_src)
                        begin
                            slot = wr_ptr[sel];
                            ring_id[sel][slot]             = id_next;
                            ring_rec[sel][slot].height     = height;
                            ring_rec[sel][slot].rate       = hashrate_bits;
                            ring_rec[sel][slot].difficulty = difficulty_bits;
                            ring_rec[sel][slot].hashes     = hash_total;
                            ring_rec[sel][slot].found      = found;
                            ring_rec[sel][slot].stamp      = timestamp;
                            id_next     = id_next + 32'd1;
                            wr_ptr[sel] = (slot + 1) % RING_DEPTH;
                            if (fill[sel] < RING_DEPTH)
                                fill[sel]++;
                        end
                    end
                    FUNC_READ:
                    begin
                        // Newest first: take the highest id among the ring heads.
                        limit = 32'((max_records > MAX_OUT) ? MAX_OUT : max_records);
                        foreach (taken[i])
                            taken[i] = 0;
                        batch.delete();
                        while (batch.size() < limit)
                        begin
                            have = 1'b0;
                            for (t = 0; t < n_src; t++)
                            begin
                                if ((everyone || t == 32'(sel)) && taken[t] < fill[t])
                                begin
                                    slot = (wr_ptr[t] + RING_DEPTH - 1 - taken[t])
                                           % RING_DEPTH;
                                    if (!have || ring_id[t][slot] > best_id)
                                    begin
                                        have      = 1'b1;
                                        best_t    = t;
                                        best_slot = slot;
                                        best_id   = ring_id[t][slot];
                                    end
                                end
                            end
                            if (!have)
                                break;
                            taken[best_t]++;
                            want.id    = best_id;
                            want.src   = best_t[2:0];
                            want.rec   = ring_rec[best_t][best_slot];
                            want.valid = 1'b1;
                            want.last  = 1'b0;
                            batch.push_back(want);
                        end
                        // A read always closes with a last beat, empty if nothing was found.
                        if (batch.size() == 0)
                        begin
                            want      = '0;
                            want.last = 1'b1;
                            batch.push_back(want);
                        end
                        else
                        begin
                            want      = batch.pop_back();
                            want.last = 1'b1;
                            batch.push_back(want);
                        end
                        foreach (batch[i])
                            beats_due.push_back(batch[i]);
                    end
                    default:
                        ;
                endcase
            end

            outstanding <= beats_due.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for the per-source history ring merge block: clock, reset,
// command and register stimulus, receiver stalls and the verdict. Uses pshrm_pkg.
module tb;

    import pshrm_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ACTIVE [NUM_PHASES] = '{1, 8, 4, 0, 15, 6, 8};
    localparam int PHASE_ITEMS  [NUM_PHASES] = '{70, 80, 70, 15, 70, 70, 75};

    // One command beat.
    typedef struct {
        func_t        op;
        logic [3:0]   src;
        rec_payload_t rec;
        logic [6:0]   count;
    } command_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [3:0]         cfg_write_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic signed [3:0]  thread;
    logic [31:0]        height;
    logic [63:0]        hashrate_bits;
    logic [63:0]        difficulty_bits;
    logic [63:0]        hash_total;
    logic               found;
    logic [31:0]        timestamp;
    logic [6:0]         max_records;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        record_id;
    logic [2:0]         source;
    logic [31:0]        out_height;
    logic [63:0]        out_rate_bits;
    logic [63:0]        out_difficulty_bits;
    logic [63:0]        out_hash_total;
    logic               out_found;
    logic [31:0]        out_time;
    logic               record_valid;
    logic               last;

    int                 failures;
    int                 outstanding;
    int                 cycle_count = 0;
    int                 send_idle_pct = 15;
    int                 recv_idle_pct = 63;
    bit                 hold_req = 1'b0;

    per_source_history_ring_merge dut (.*);
    ring_merge_checker u_checker (.*);

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin : receiver
        bit hold_done;

        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic command_t command(func_t op, logic [3:0] src, rec_payload_t rec,
                                         logic [6:0] count);
        command_t c;

        c.op    = op;
        c.src   = src;
        c.rec   = rec;
        c.count = count;
        return c;
    endfunction

    // Offers one command beat, after an optional gap, and returns once it is taken.
    // Valid is left high so that a following beat can go out back to back.
    task automatic send_command(command_t c);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid        <= 1'b1;
        func            <= c.op;
        thread          <= c.src;
        height          <= c.rec.height;
        hashrate_bits   <= c.rec.rate;
        difficulty_bits <= c.rec.difficulty;
        hash_total      <= c.rec.hashes;
        found           <= c.rec.found;
        timestamp       <= c.rec.stamp;
        max_records     <= c.count;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Writes the source count once the block has gone quiet.
    task automatic set_active(logic [3:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic rec_payload_t random_record();
        rec_payload_t rec;

        rec.height     = $urandom;
        rec.rate       = {$urandom, $urandom};
        rec.difficulty = {$urandom, $urandom};
        rec.hashes     = {$urandom, $urandom};
        rec.found      = 1'($urandom_range(0, 1));
        rec.stamp      = $urandom;
        return rec;
    endfunction

    initial
    begin : stimulus
        rec_payload_t zero_rec;
        rec_payload_t ones_rec;
        logic [3:0]   src;
        logic [6:0]   count;
        int           pick;
        int           n_act;
        int           k;

        zero_rec = '0;
        ones_rec = '1;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_write_data  = '0;
        in_valid        = 1'b0;
        func            = FUNC_NONE;
        thread          = '0;
        height          = '0;
        hashrate_bits   = '0;
        difficulty_bits = '0;
        hash_total      = '0;
        found           = 1'b0;
        timestamp       = '0;
        max_records     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with all eight sources in use.
        set_active(4'd8);
        send_command(command(FUNC_READ, 4'hF, zero_rec, 7'd64));    // empty history
        send_command(command(FUNC_ADD, 4'd0, zero_rec, 7'd0));
        send_command(command(FUNC_ADD, 4'd7, ones_rec, 7'd127));
        send_command(command(FUNC_ADD, 4'hF, ones_rec, 7'd0));      // negative source
        send_command(command(FUNC_ADD, 4'h8, random_record(), 7'd0));
        send_command(command(FUNC_NONE, 4'h7, ones_rec, 7'd127));   // unused code
        send_command(command(FUNC_READ, 4'd7, zero_rec, 7'd1));
        send_command(command(FUNC_READ, 4'hF, zero_rec, 7'd0));     // nothing asked for
        send_command(command(FUNC_READ, 4'hF, zero_rec, 7'd127));   // above the cap
        // Nine adds wrap the ring of source 2 and push out its oldest record.
        for (k = 0; k < 9; k++)
            send_command(command(FUNC_ADD, 4'd2, random_record(), 7'd0));
        send_command(command(FUNC_READ, 4'd2, zero_rec, 7'd64));
        send_command(command(FUNC_READ, 4'h8, zero_rec, 7'd5));
        send_command(command(FUNC_CLEAR, 4'd0, ones_rec, 7'd0));
        send_command(command(FUNC_READ, 4'hF, zero_rec, 7'd64));

        // Random phases over several source counts and idling profiles.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 63;
            end
            else if (phase < 5)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_active(4'(PHASE_ACTIVE[phase]));
            n_act = (PHASE_ACTIVE[phase] > 8) ? 8 : PHASE_ACTIVE[phase];
            for (k = 0; k < PHASE_ITEMS[phase]; k++)
            begin
                // Once the rings are well filled, stall the receiver for a long stretch.
                if (phase == NUM_PHASES - 1 && k == 30)
                    hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    if (n_act > 0 && $urandom_range(0, 99) < 85)
                        src = 4'($urandom_range(0, n_act - 1));
                    else
                        src = 4'($urandom_range(0, 15));
                    send_command(command(FUNC_ADD, src, random_record(),
                                         7'($urandom_range(0, 127))));
                end
                else if (pick < 96)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        src = 4'hF;
                    else if (pick < 6)
                        src = 4'($urandom_range(8, 15));
                    else
                        src = 4'($urandom_range(0, 7));
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        count = 7'($urandom_range(1, 12));
                    else if (pick < 85)
                        count = 7'($urandom_range(13, 64));
                    else if (pick < 93)
                        count = 7'd64;
                    else if (pick < 97)
                        count = 7'($urandom_range(65, 127));
                    else
                        count = 7'd0;
                    send_command(command(FUNC_READ, src, random_record(), count));
                end
                else if (pick < 98)
                    send_command(command(FUNC_CLEAR, 4'($urandom_range(0, 15)),
                                         random_record(), 7'($urandom_range(0, 127))));
                else
                    send_command(command(FUNC_NONE, 4'($urandom_range(0, 15)),
                                         random_record(), 7'($urandom_range(0, 127))));
            end
        end

        // Let every due beat arrive, then allow the block to settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/pshrm_pkg.sv
src/per_source_history_ring_merge.sv
bench/ring_merge_checker.sv
bench/tb.sv
